// File: hw/rtl/lrpe_pkg.sv
// Shared constants, register indexes and the Q8.8 scaling function
// for the lane row peak extractor. No dependencies.

package lrpe_pkg;

   // Default size limits of the probability map
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   // Field widths
   localparam int PROB_W  = 16;
   localparam int SIZE_W  = 11;
   localparam int SCALE_W = 16;
   localparam int OUT_W   = 18;
   localparam int ROWS_W  = 10;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 16;
   localparam int RSP_DW  = 64;

   localparam logic [OUT_W-1:0]  OUT_MAX      = 18'h3FFFF;
   localparam logic [ROWS_W-1:0] ROWS_MAX     = 10'd1023;
   localparam logic [ROWS_W-1:0] MIN_HIT_ROWS = 10'd5;

   // Register indexes on the csr port
   localparam logic [CSR_AW-1:0] REG_THRESHOLD  = 3'd0;
   localparam logic [CSR_AW-1:0] REG_MAP_WIDTH  = 3'd1;
   localparam logic [CSR_AW-1:0] REG_MAP_HEIGHT = 3'd2;
   localparam logic [CSR_AW-1:0] REG_X_SCALE    = 3'd3;
   localparam logic [CSR_AW-1:0] REG_Y_SCALE    = 3'd4;

   // Reset values of the registers
   localparam logic [PROB_W-1:0]  THRESHOLD_RST = 16'd32768;
   localparam logic [SIZE_W-1:0]  SIZE_RST      = 11'd256;
   localparam logic [SCALE_W-1:0] SCALE_RST     = 16'd256;

   // (pos * factor) >> 8, saturated to the output field width
   function automatic logic [OUT_W-1:0] scale_q88(input logic [15:0] pos,
                                                  input logic [SCALE_W-1:0] factor);
      logic [31:0] prod;
      logic [23:0] shifted;
      prod    = 32'(pos) * 32'(factor);
      shifted = prod[31:8];
      if (shifted > 24'(OUT_MAX)) begin
         return OUT_MAX;
      end
      return shifted[OUT_W-1:0];
   endfunction

endpackage

// File: hw/rtl/lane_row_peak_extractor.sv
// Lane row peak extractor: accepts one pixel per cycle. A row result reaches rsp through the
// input register, the row record and the scaled result register once the last pixel of a
// lower-half row is accepted. The input stalls only when a pixel ending a lower-half row finds
// the record stage and the result register both held by rsp_tready low.
// Synchronous active-high reset clears counters, peaks and hit counts and loads the register
// defaults (threshold 32768, 256x256 map, unit scales). Depends on lrpe_pkg.

module lane_row_peak_extractor #(
   parameter int MAX_WIDTH  = lrpe_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lrpe_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // pixel stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lrpe_pkg::PROB_W-1:0]   req_tdata,   // [15:0] prob
   // row results
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lrpe_pkg::RSP_DW-1:0]   rsp_tdata,   // [0] left_found, [18:1] left_x,
                                                      // [19] right_found, [37:20] right_x,
                                                      // [55:38] row_y, [56] left_valid,
                                                      // [57] right_valid, [63:58] zero
   output logic                          rsp_tlast,   // frame_end
   // configuration
   input  logic                          csr_we,
   input  logic [lrpe_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [lrpe_pkg::CSR_DW-1:0]   csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int WVW   = $clog2(MAX_WIDTH + 1);
   localparam int HVW   = $clog2(MAX_HEIGHT + 1);
   localparam int WCMPW = (lrpe_pkg::SIZE_W > WVW) ? lrpe_pkg::SIZE_W : WVW;
   localparam int HCMPW = (lrpe_pkg::SIZE_W > HVW) ? lrpe_pkg::SIZE_W : HVW;
   localparam int OW    = lrpe_pkg::OUT_W;

   // ---------------- configuration registers ----------------
   logic [lrpe_pkg::PROB_W-1:0]  threshold_ff;
   logic [lrpe_pkg::SIZE_W-1:0]  map_width_ff, map_height_ff;
   logic [lrpe_pkg::SCALE_W-1:0] x_scale_ff, y_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= lrpe_pkg::THRESHOLD_RST;
         map_width_ff  <= lrpe_pkg::SIZE_RST;
         map_height_ff <= lrpe_pkg::SIZE_RST;
         x_scale_ff    <= lrpe_pkg::SCALE_RST;
         y_scale_ff    <= lrpe_pkg::SCALE_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            lrpe_pkg::REG_THRESHOLD:  threshold_ff  <= csr_wdata;
            lrpe_pkg::REG_MAP_WIDTH:  map_width_ff  <= csr_wdata[lrpe_pkg::SIZE_W-1:0];
            lrpe_pkg::REG_MAP_HEIGHT: map_height_ff <= csr_wdata[lrpe_pkg::SIZE_W-1:0];
            lrpe_pkg::REG_X_SCALE:    x_scale_ff    <= csr_wdata;
            lrpe_pkg::REG_Y_SCALE:    y_scale_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp sizes to [2, MAX] and derive the half and last indexes
   logic [WCMPW-1:0] w_raw, w_cl;
   logic [HCMPW-1:0] h_raw, h_cl;
   logic [CW-1:0]    w_half, w_last;
   logic [RW-1:0]    h_half, h_last;

   always_comb begin
      w_raw = WCMPW'(map_width_ff);
      h_raw = HCMPW'(map_height_ff);
      priority if (w_raw < WCMPW'(2))         w_cl = WCMPW'(2);
      else if (w_raw > WCMPW'(MAX_WIDTH))     w_cl = WCMPW'(MAX_WIDTH);
      else                                    w_cl = w_raw;
      priority if (h_raw < HCMPW'(2))         h_cl = HCMPW'(2);
      else if (h_raw > HCMPW'(MAX_HEIGHT))    h_cl = HCMPW'(MAX_HEIGHT);
      else                                    h_cl = h_raw;
      w_half = CW'(w_cl >> 1);
      w_last = CW'(w_cl - WCMPW'(1));
      h_half = RW'(h_cl >> 1);
      h_last = RW'(h_cl - HCMPW'(1));
   end

   // ---------------- pipeline control ----------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free, s2_move, s2_free, s1_go, emit;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s2_move    = s2_valid_ff && out_free;
   assign s2_free    = !s2_valid_ff || out_free;
   // only a pixel that closes a lower-half row needs room downstream
   assign s1_go      = s1_valid_ff && (s2_free || !emit);
   assign req_tready = !s1_valid_ff || s1_go;

   always_comb begin
      s1_valid_in  = req_tvalid ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      s2_valid_in  = (s1_go && emit) ? 1'b1 : (s2_move ? 1'b0 : s2_valid_ff);
      out_valid_in = s2_move ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      if (!req_tready) begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ---------------- stage 1: input register ----------------
   logic [lrpe_pkg::PROB_W-1:0] prob_ff;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         prob_ff <= req_tdata;
      end
   end

   // ---------------- peak tracking state ----------------
   logic [CW-1:0]                col_ff, col_in;
   logic [RW-1:0]                row_ff, row_in;
   logic [lrpe_pkg::PROB_W-1:0]  lmax_ff, lmax_in, rmax_ff, rmax_in;
   logic [CW-1:0]                lbest_ff, lbest_in, rbest_ff, rbest_in;
   logic                         lhit_ff, lhit_in, rhit_ff, rhit_in;
   logic [lrpe_pkg::ROWS_W-1:0]  lrows_ff, lrows_in, rrows_ff, rrows_in;

   logic lower, row_end, frame_end, above, in_left, l_take, r_take;
   logic l_hit_nx, r_hit_nx;
   logic [CW-1:0] l_best_nx, r_best_nx;
   logic [lrpe_pkg::PROB_W-1:0] l_max_nx, r_max_nx;
   logic [lrpe_pkg::ROWS_W-1:0] l_rows_nx, r_rows_nx;

   always_comb begin
      lower     = row_ff >= h_half;
      row_end   = col_ff >= w_last;
      frame_end = row_end && (row_ff >= h_last);
      emit      = row_end && lower;
      above     = lower && (prob_ff > threshold_ff);
      in_left   = col_ff < w_half;
      l_take    = above && in_left && (prob_ff > lmax_ff);
      r_take    = above && !in_left && (prob_ff > rmax_ff);

      l_max_nx  = l_take ? prob_ff : lmax_ff;
      l_best_nx = l_take ? col_ff  : lbest_ff;
      l_hit_nx  = lhit_ff || l_take;
      r_max_nx  = r_take ? prob_ff : rmax_ff;
      r_best_nx = r_take ? col_ff  : rbest_ff;
      r_hit_nx  = rhit_ff || r_take;

      l_rows_nx = lrows_ff;
      r_rows_nx = rrows_ff;
      if (emit && l_hit_nx && (lrows_ff < lrpe_pkg::ROWS_MAX)) begin
         l_rows_nx = lrows_ff + 1'b1;
      end
      if (emit && r_hit_nx && (rrows_ff < lrpe_pkg::ROWS_MAX)) begin
         r_rows_nx = rrows_ff + 1'b1;
      end

      col_in   = col_ff;
      row_in   = row_ff;
      lmax_in  = lmax_ff;
      lbest_in = lbest_ff;
      lhit_in  = lhit_ff;
      rmax_in  = rmax_ff;
      rbest_in = rbest_ff;
      rhit_in  = rhit_ff;
      lrows_in = lrows_ff;
      rrows_in = rrows_ff;
      if (s1_go) begin
         if (row_end) begin
            col_in   = '0;
            lmax_in  = '0;
            lbest_in = '0;
            lhit_in  = 1'b0;
            rmax_in  = '0;
            rbest_in = '0;
            rhit_in  = 1'b0;
            if (frame_end) begin
               row_in   = '0;
               lrows_in = '0;
               rrows_in = '0;
            end else begin
               row_in   = row_ff + 1'b1;
               lrows_in = l_rows_nx;
               rrows_in = r_rows_nx;
            end
         end else begin
            col_in   = col_ff + 1'b1;
            lmax_in  = l_max_nx;
            lbest_in = l_best_nx;
            lhit_in  = l_hit_nx;
            rmax_in  = r_max_nx;
            rbest_in = r_best_nx;
            rhit_in  = r_hit_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         lmax_ff  <= '0;
         lbest_ff <= '0;
         lhit_ff  <= 1'b0;
         rmax_ff  <= '0;
         rbest_ff <= '0;
         rhit_ff  <= 1'b0;
         lrows_ff <= '0;
         rrows_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         lmax_ff  <= lmax_in;
         lbest_ff <= lbest_in;
         lhit_ff  <= lhit_in;
         rmax_ff  <= rmax_in;
         rbest_ff <= rbest_in;
         rhit_ff  <= rhit_in;
         lrows_ff <= lrows_in;
         rrows_ff <= rrows_in;
      end
   end

   // ---------------- stage 2: row record ----------------
   logic          rec_lfound_ff, rec_rfound_ff, rec_last_ff, rec_lvalid_ff, rec_rvalid_ff;
   logic [CW-1:0] rec_lcol_ff, rec_rcol_ff;
   logic [RW-1:0] rec_row_ff;

   always_ff @(posedge clock) begin
      if (s1_go && emit) begin
         rec_lfound_ff <= l_hit_nx;
         rec_lcol_ff   <= l_best_nx;
         rec_rfound_ff <= r_hit_nx;
         rec_rcol_ff   <= r_best_nx;
         rec_row_ff    <= row_ff;
         rec_last_ff   <= frame_end;
         rec_lvalid_ff <= frame_end && (l_rows_nx > lrpe_pkg::MIN_HIT_ROWS);
         rec_rvalid_ff <= frame_end && (r_rows_nx > lrpe_pkg::MIN_HIT_ROWS);
      end
   end

   // ---------------- stage 3: scaling into the result register ----------------
   logic [OW-1:0] lx_in, rx_in, ry_in;
   logic [OW-1:0] lx_ff, rx_ff, ry_ff;
   logic          lfound_ff, rfound_ff, last_ff, lvalid_ff, rvalid_ff;

   always_comb begin
      lx_in = rec_lfound_ff ? lrpe_pkg::scale_q88(16'(rec_lcol_ff), x_scale_ff) : '0;
      rx_in = rec_rfound_ff ? lrpe_pkg::scale_q88(16'(rec_rcol_ff), x_scale_ff) : '0;
      ry_in = lrpe_pkg::scale_q88(16'(rec_row_ff), y_scale_ff);
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         lx_ff     <= lx_in;
         rx_ff     <= rx_in;
         ry_ff     <= ry_in;
         lfound_ff <= rec_lfound_ff;
         rfound_ff <= rec_rfound_ff;
         last_ff   <= rec_last_ff;
         lvalid_ff <= rec_lvalid_ff;
         rvalid_ff <= rec_rvalid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {6'd0, rvalid_ff, lvalid_ff, ry_ff, rx_ff, rfound_ff, lx_ff, lfound_ff};

   // ---------------- assertions ----------------
   // a pixel waits in the input register only if it must hand off a row record
   a_s1_stall_only_on_emit: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |-> emit)
      else $error("input stage stalled on a pixel that emits nothing");

   // end of frame clears the row counter and the hit counts
   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_go && frame_end) |=> (row_ff == '0 && lrows_ff == '0 && rrows_ff == '0))
      else $error("frame end did not clear row and hit counters");

   // side-valid flags only on the frame's last row
   a_valid_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[56] || rsp_tdata[57])) |-> rsp_tlast)
      else $error("side valid flag outside frame end");

   // no peak means a zero column
   a_no_peak_zero_x: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[18:1] == '0))
      else $error("left_x nonzero without a left peak");

endmodule

// File: test/lane_row_peak_extractor_tb.sv
// Testbench for lane_row_peak_extractor: directed frames, a wide row, a tall frame, then
// random sizes, thresholds, scales; rows checked against the table or an in-bench model.
// Depends on lrpe_pkg and the lane_row_peak_extractor RTL.

module lane_row_peak_extractor_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int TOTAL_PIXELS   = 950;
   localparam int IDLE_OFF_AFTER = 800;
   localparam int WIDE_COLS      = 600;
   localparam int TALL_ROWS      = 40;
   localparam int MAX_W          = lrpe_pkg::MAX_WIDTH_DEF;
   localparam int MAX_H          = lrpe_pkg::MAX_HEIGHT_DEF;
   localparam logic [lrpe_pkg::CSR_AW-1:0] NO_ADDR = '0;

   typedef struct packed {
      logic        left_found;
      logic [17:0] left_x;
      logic        right_found;
      logic [17:0] right_x;
      logic [17:0] row_y;
      logic        frame_end;
      logic        left_valid;
      logic        right_valid;
   } row_peaks_type;

   typedef enum logic {STEP_CFG, STEP_PIX} step_kind_type;

   typedef struct packed {
      step_kind_type                 kind;
      logic [lrpe_pkg::CSR_AW-1:0]   addr;
      logic [15:0]                   value;
      logic                          has_exp;
      row_peaks_type                 exp_row;
   } dir_step_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [lrpe_pkg::PROB_W-1:0]   req_tdata  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b1;
   logic [lrpe_pkg::RSP_DW-1:0]   rsp_tdata;
   logic                          rsp_tlast;
   logic                          csr_we     = 1'b0;
   logic [lrpe_pkg::CSR_AW-1:0]   csr_addr   = '0;
   logic [lrpe_pkg::CSR_DW-1:0]   csr_wdata  = '0;

   lane_row_peak_extractor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // model copy of the configuration
   logic [15:0] cfg_threshold = lrpe_pkg::THRESHOLD_RST;
   logic [10:0] cfg_width     = lrpe_pkg::SIZE_RST;
   logic [10:0] cfg_height    = lrpe_pkg::SIZE_RST;
   logic [15:0] cfg_x_scale   = lrpe_pkg::SCALE_RST;
   logic [15:0] cfg_y_scale   = lrpe_pkg::SCALE_RST;

   // model copy of the scan state
   int unsigned col_pos, row_pos;
   int unsigned left_peak, left_col, right_peak, right_col;
   bit          left_seen, right_seen;
   int unsigned left_hit_rows, right_hit_rows;

   row_peaks_type pending_rows[$];
   dir_step_type  dir_tab[$];
   int            errors       = 0;
   int            rows_checked = 0;
   int unsigned   px_sent      = 0;
   bit            idle_on      = 1'b0;
   int            stall_left   = 0;
   int            quiet_cycles = 0;
   logic [15:0]   last_prob    = '0;

   function automatic int unsigned eff_size(input logic [10:0] v, input int unsigned hi);
      if (v < 11'd2) return 2;
      if (v > hi) return hi;
      return 32'(v);
   endfunction

   function automatic logic [17:0] to_image(input int unsigned pos, input logic [15:0] factor);
      logic [63:0] prod;
      prod = (64'(pos) * 64'(factor)) >> 8;
      if (prod > 64'(lrpe_pkg::OUT_MAX)) return lrpe_pkg::OUT_MAX;
      return prod[17:0];
   endfunction

   // One pixel through the scan model; emit is set at the end of a lower-half row.
   task automatic track_pixel(input logic [15:0] p, output bit emit, output row_peaks_type r);
      int unsigned w, h;
      bit          lower, row_end, last_row;
      w        = eff_size(cfg_width, MAX_W);
      h        = eff_size(cfg_height, MAX_H);
      lower    = row_pos >= h / 2;
      row_end  = col_pos >= w - 1;
      last_row = row_end && row_pos >= h - 1;
      emit     = 1'b0;
      r        = '0;
      if (lower && p > cfg_threshold) begin
         if (col_pos < w / 2) begin
            if (p > left_peak) begin
               left_peak = 32'(p);
               left_col  = col_pos;
               left_seen = 1'b1;
            end
         end else if (p > right_peak) begin
            right_peak = 32'(p);
            right_col  = col_pos;
            right_seen = 1'b1;
         end
      end
      if (row_end) begin
         if (lower) begin
            if (left_seen && left_hit_rows < lrpe_pkg::ROWS_MAX) left_hit_rows++;
            if (right_seen && right_hit_rows < lrpe_pkg::ROWS_MAX) right_hit_rows++;
            r.left_found  = left_seen;
            r.left_x      = left_seen ? to_image(left_col, cfg_x_scale) : '0;
            r.right_found = right_seen;
            r.right_x     = right_seen ? to_image(right_col, cfg_x_scale) : '0;
            r.row_y       = to_image(row_pos, cfg_y_scale);
            r.frame_end   = last_row;
            r.left_valid  = last_row && left_hit_rows > lrpe_pkg::MIN_HIT_ROWS;
            r.right_valid = last_row && right_hit_rows > lrpe_pkg::MIN_HIT_ROWS;
            emit          = 1'b1;
         end
         left_peak  = 0;
         left_col   = 0;
         left_seen  = 1'b0;
         right_peak = 0;
         right_col  = 0;
         right_seen = 1'b0;
         col_pos    = 0;
         if (last_row) begin
            row_pos        = 0;
            left_hit_rows  = 0;
            right_hit_rows = 0;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
   endtask

   // Bias toward threshold edges and repeats so ties and strict compares get hit.
   function automatic logic [15:0] pick_prob();
      logic [15:0] p;
      case ($urandom_range(0, 9))
         0: p = 16'h0000;
         1: p = 16'hFFFF;
         2: p = cfg_threshold;
         3: p = cfg_threshold + 16'd1;
         4: p = last_prob;
         default: p = 16'($urandom);
      endcase
      last_prob = p;
      return p;
   endfunction

   function automatic void add_cfg(input logic [lrpe_pkg::CSR_AW-1:0] addr,
                                   input logic [15:0] value);
      dir_tab.insert(dir_tab.size(),
                     dir_step_type'{STEP_CFG, addr, value, 1'b0, row_peaks_type'(0)});
   endfunction

   function automatic void add_pix(input logic [15:0] p);
      dir_tab.insert(dir_tab.size(),
                     dir_step_type'{STEP_PIX, NO_ADDR, p, 1'b0, row_peaks_type'(0)});
   endfunction

   function automatic void add_row(input logic [15:0] p, input row_peaks_type r);
      dir_tab.insert(dir_tab.size(), dir_step_type'{STEP_PIX, NO_ADDR, p, 1'b1, r});
   endfunction

   task automatic write_reg(input logic [lrpe_pkg::CSR_AW-1:0] addr, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      case (addr)
         lrpe_pkg::REG_THRESHOLD:  cfg_threshold = value;
         lrpe_pkg::REG_MAP_WIDTH:  cfg_width     = value[10:0];
         lrpe_pkg::REG_MAP_HEIGHT: cfg_height    = value[10:0];
         lrpe_pkg::REG_X_SCALE:    cfg_x_scale   = value;
         lrpe_pkg::REG_Y_SCALE:    cfg_y_scale   = value;
         default: ;
      endcase
   endtask

   // csr_we drops here too, so a run of writes keeps it high without a gap
   task automatic send_pixel(input logic [15:0] p, input bit has_exp,
                             input row_peaks_type typed);
      bit            emit;
      row_peaks_type r;
      int            gap;
      csr_we <= 1'b0;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      do @(posedge clock); while (!req_tready);
      px_sent++;
      track_pixel(p, emit, r);
      if (emit) pending_rows.insert(pending_rows.size(), has_exp ? typed : r);
   endtask

   // Wait out every pending row, then the pipeline, before touching registers.
   task automatic drain();
      req_tvalid <= 1'b0;
      csr_we     <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      row_peaks_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.left_found  = rsp_tdata[0];
         got.left_x      = rsp_tdata[18:1];
         got.right_found = rsp_tdata[19];
         got.right_x     = rsp_tdata[37:20];
         got.row_y       = rsp_tdata[55:38];
         got.frame_end   = rsp_tlast;
         got.left_valid  = rsp_tdata[56];
         got.right_valid = rsp_tdata[57];
         if (pending_rows.size() == 0) begin
            $display("%0t: row result transaction with nothing expected, actual %h",
                     $time, got);
            errors++;
         end else begin
            want = pending_rows.pop_front();
            rows_checked++;
            check_field("left_found", 32'(want.left_found), 32'(got.left_found));
            check_field("left_x", 32'(want.left_x), 32'(got.left_x));
            check_field("right_found", 32'(want.right_found), 32'(got.right_found));
            check_field("right_x", 32'(want.right_x), 32'(got.right_x));
            check_field("row_y", 32'(want.row_y), 32'(got.row_y));
            check_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
            check_field("left_valid", 32'(want.left_valid), 32'(got.left_valid));
            check_field("right_valid", 32'(want.right_valid), 32'(got.right_valid));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int          n;
      logic [15:0] v;

      // 4x2 map: upper row ignored, equal-to-threshold rejected, tie keeps first column
      add_cfg(lrpe_pkg::REG_THRESHOLD, 16'd100);
      add_cfg(lrpe_pkg::REG_MAP_WIDTH, 16'd4);
      add_cfg(lrpe_pkg::REG_MAP_HEIGHT, 16'd2);
      repeat (4) add_pix(16'hFFFF);
      add_pix(16'd100);
      add_pix(16'd101);
      add_pix(16'hFFFF);
      add_row(16'hFFFF, row_peaks_type'{1'b1, 18'd1, 1'b1, 18'd2, 18'd1, 1'b1, 1'b0, 1'b0});
      // zero threshold, full-scale factors, right half empty
      add_cfg(lrpe_pkg::REG_THRESHOLD, 16'd0);
      add_cfg(lrpe_pkg::REG_X_SCALE, 16'hFFFF);
      add_cfg(lrpe_pkg::REG_Y_SCALE, 16'hFFFF);
      repeat (4) add_pix(16'd0);
      add_pix(16'd0);
      add_pix(16'd1);
      add_pix(16'd0);
      add_row(16'd0, row_peaks_type'{1'b1, 18'd255, 1'b0, 18'd0, 18'd255, 1'b1, 1'b0, 1'b0});
      // max threshold never exceeded; undersized map clamps to 2x2
      add_cfg(lrpe_pkg::REG_THRESHOLD, 16'hFFFF);
      add_cfg(lrpe_pkg::REG_X_SCALE, 16'd0);
      add_cfg(lrpe_pkg::REG_Y_SCALE, 16'd0);
      add_cfg(lrpe_pkg::REG_MAP_WIDTH, 16'd0);
      add_cfg(lrpe_pkg::REG_MAP_HEIGHT, 16'd1);
      repeat (3) add_pix(16'hFFFF);
      add_row(16'hFFFF, row_peaks_type'{1'b0, 18'd0, 1'b0, 18'd0, 18'd0, 1'b1, 1'b0, 1'b0});
      // width shrinks mid-row: column past the new end closes the row at once
      add_cfg(lrpe_pkg::REG_MAP_WIDTH, 16'd4);
      repeat (3) add_pix(16'hFFFF);
      add_cfg(lrpe_pkg::REG_MAP_WIDTH, 16'd2);
      repeat (3) add_pix(16'hFFFF);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == STEP_CFG) begin
            if (i == 0 || dir_tab[i-1].kind == STEP_PIX) drain();
            write_reg(dir_tab[i].addr, dir_tab[i].value);
         end else begin
            send_pixel(dir_tab[i].value, dir_tab[i].has_exp, dir_tab[i].exp_row);
         end
      end

      // wide row: a two-pixel upper row, then one long lower row, columns reach the top bits
      drain();
      write_reg(lrpe_pkg::REG_THRESHOLD, 16'd1000);
      write_reg(lrpe_pkg::REG_MAP_WIDTH, 16'd2);
      write_reg(lrpe_pkg::REG_MAP_HEIGHT, 16'd2);
      write_reg(lrpe_pkg::REG_X_SCALE, 16'hFFFF);
      repeat (2) send_pixel(pick_prob(), 1'b0, row_peaks_type'(0));
      drain();
      write_reg(lrpe_pkg::REG_MAP_WIDTH, 16'(WIDE_COLS));
      repeat (WIDE_COLS) send_pixel(pick_prob(), 1'b0, row_peaks_type'(0));

      // taller frame of narrow rows, long run of hit rows for the valid flags
      drain();
      write_reg(lrpe_pkg::REG_MAP_WIDTH, 16'd1);
      write_reg(lrpe_pkg::REG_MAP_HEIGHT, 16'(TALL_ROWS));
      write_reg(lrpe_pkg::REG_Y_SCALE, 16'hFFFF);
      repeat (2 * TALL_ROWS) send_pixel(pick_prob(), 1'b0, row_peaks_type'(0));

      while (px_sent < TOTAL_PIXELS) begin
         drain();
         idle_on = (px_sent < IDLE_OFF_AFTER) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 7))
               0: v = 16'h0000;
               1: v = 16'hFFFF;
               2, 3: v = 16'($urandom);
               default: v = 16'($urandom_range(0, 24000));
            endcase
            write_reg(lrpe_pkg::REG_THRESHOLD, v);
         end
         if (cfg_width > 11'd16 || $urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 11))
               0: v = 16'($urandom_range(0, 1));
               1: v = 16'($urandom_range(1025, 2047));
               default: v = 16'($urandom_range(2, 12));
            endcase
            write_reg(lrpe_pkg::REG_MAP_WIDTH, v);
         end
         if (cfg_height > 11'd32 || $urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 11))
               0: v = 16'($urandom_range(0, 1));
               1: v = 16'($urandom_range(1025, 2047));
               2, 3: v = 16'($urandom_range(17, 32));
               default: v = 16'($urandom_range(2, 16));
            endcase
            write_reg(lrpe_pkg::REG_MAP_HEIGHT, v);
         end
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
               0: v = 16'h0000;
               1: v = 16'hFFFF;
               default: v = 16'($urandom);
            endcase
            write_reg(lrpe_pkg::REG_X_SCALE, v);
         end
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
               0: v = 16'h0000;
               1: v = 16'hFFFF;
               default: v = 16'($urandom);
            endcase
            write_reg(lrpe_pkg::REG_Y_SCALE, v);
         end
         n = $urandom_range(20, 140);
         if (n > int'(TOTAL_PIXELS - px_sent)) n = int'(TOTAL_PIXELS - px_sent);
         repeat (n) send_pixel(pick_prob(), 1'b0, row_peaks_type'(0));
      end

      drain();
      if (errors == 0 && pending_rows.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: lane_row_peak_extractor.f
hw/rtl/lrpe_pkg.sv
hw/rtl/lane_row_peak_extractor.sv
test/lane_row_peak_extractor_tb.sv
